// File: sv/lpbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpbp_pkg
// Types and codes shared by the log packet block packer and its channels.
// ----------------------------------------------------------------------------
package lpbp_pkg;

	localparam int DATA_BYTES_DEF = 504;
	localparam int MAX_PACKET_DEF = 250;

	// input modes
	localparam logic [1:0] MODE_DATA    = 2'd0;
	localparam logic [1:0] MODE_FLUSH   = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_DATA  = 3'd0;
	localparam logic [2:0] KIND_SIZE  = 3'd1;
	localparam logic [2:0] KIND_FULL  = 3'd2;
	localparam logic [2:0] KIND_FLUSH = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	// configuration register indexes
	localparam logic [7:0] REG_BLOCK_COUNT = 8'd0;
	localparam logic [7:0] REG_START_BLOCK = 8'd1;
	localparam logic [7:0] REG_START_FILL  = 8'd2;
	localparam logic [7:0] REG_START_ID    = 8'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] payload;
		logic [7:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] block_number;
		logic [8:0]  offset;
		logic [7:0]  byte_value;
		logic [63:0] trailer_id;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [63:0] value;
	} cfg_item_t;

endpackage
`default_nettype wire

// File: sv/lpbp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpbp_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface lpbp_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/log_packet_block_packer.sv
`default_nettype none
// path: an accepted item is registered in the input stage, then in the result buffer, which presents its first result
// throughput: one item per cycle while each item yields at most one result and res.ready is high;
// an item with several results holds the result buffer until its last one is being taken
// restart items give no result
// reset: asynchronous, clears block, fill, packet id and packet progress,
// block_count returns to one and the start registers to zero
// ----------------------------------------------------------------------------
// log_packet_block_packer
// Packs byte-serial log packets into a circular log of fixed-size blocks,
// emitting data writes, size bytes, block flush events and error results.
// ----------------------------------------------------------------------------
module log_packet_block_packer
	import lpbp_pkg::*;
#(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lpbp_if.sink      pkt,
	lpbp_if.source    res,
	lpbp_if.sink      cfg
);

	localparam int FILL_W = $clog2(DATA_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DATA_BYTES);

	// configuration
	logic [31:0] block_count_q;
	logic [31:0] start_block_q;
	logic [8:0]  start_fill_q;
	logic [63:0] start_id_q;

	// packer state
	logic [31:0]       wb_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       id_q;
	logic [7:0]        bip_q;
	logic [7:0]        held_q;

	// input stage
	logic       v_s1;
	logic [1:0] mode_s1;
	logic [7:0] payload_s1;
	logic [7:0] len_s1;

	// result buffer, entry 0 is presented
	out_item_t res_q [3];
	logic [1:0] cnt_q;

	logic buf_ok;
	logic load;

	logic [31:0]       wb_n;
	logic [FILL_W-1:0] fill_n;
	logic [63:0]       id_n;
	logic [7:0]        bip_n;
	logic [7:0]        held_n;
	out_item_t         new_res [3];
	logic [1:0]        new_n;

	logic [7:0]        hl;
	logic [7:0]        bip_inc;
	logic [FILL_W-1:0] remaining;
	logic [FILL_W-1:0] f1;
	logic [31:0]       blk;
	logic [32:0]       wb_inc;
	logic [31:0]       nb;
	logic              full;

	assign buf_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && res.ready);
	assign load = v_s1 && buf_ok;
	assign pkt.ready = !v_s1 || buf_ok;
	assign cfg.ready = 1'b1;
	assign res.valid = (cnt_q != 2'd0);
	assign res.data = res_q[0];

	always_comb begin
		wb_n = wb_q;
		fill_n = fill_q;
		id_n = id_q;
		bip_n = bip_q;
		held_n = held_q;
		new_n = 2'd0;
		for (int i = 0; i < 3; i++) begin
			new_res[i] = '0;
		end
		hl = (bip_q == 8'd0) ? len_s1 : held_q;
		bip_inc = bip_q + 8'd1;
		remaining = (fill_q < FILL_MAX) ? FILL_MAX - fill_q : '0;
		wb_inc = {1'b0, wb_q} + 33'd1;
		nb = (wb_inc >= {1'b0, block_count_q}) ? 32'd0 : wb_inc[31:0];
		full = (bip_q == 8'd0) && (remaining <= FILL_W'(hl));
		blk = full ? nb : wb_q;
		f1 = full ? '0 : fill_q;
		case (mode_s1)
			MODE_DATA: begin
				if (bip_q == 8'd0 && (len_s1 == 8'd0 || len_s1 > 8'(MAX_PACKET))) begin
					new_res[0].kind = KIND_ERROR;
					new_res[0].block_number = wb_q;
					new_n = 2'd1;
				end else begin
					held_n = hl;
					// full-block flush comes ahead of the first byte
					if (full) begin
						new_res[0].kind = KIND_FULL;
						new_res[0].block_number = wb_q;
						new_res[0].trailer_id = id_q;
						new_n = 2'd1;
					end
					new_res[new_n].kind = KIND_DATA;
					new_res[new_n].block_number = blk;
					new_res[new_n].offset = 9'(f1);
					new_res[new_n].byte_value = payload_s1;
					new_n = new_n + 2'd1;
					wb_n = blk;
					fill_n = f1 + FILL_W'(1);
					bip_n = bip_inc;
					if (bip_inc >= hl) begin
						new_res[new_n].kind = KIND_SIZE;
						new_res[new_n].block_number = blk;
						new_res[new_n].offset = 9'(f1 + FILL_W'(1));
						new_res[new_n].byte_value = hl;
						new_n = new_n + 2'd1;
						fill_n = f1 + FILL_W'(2);
						id_n = id_q + 64'd1;
						bip_n = 8'd0;
					end
				end
			end
			MODE_FLUSH: begin
				new_res[0].kind = KIND_FLUSH;
				new_res[0].block_number = wb_q;
				new_res[0].trailer_id = id_q;
				new_n = 2'd1;
			end
			MODE_RESTART: begin
				wb_n = (start_block_q < block_count_q) ? start_block_q : 32'd0;
				fill_n = (FILL_W'(start_fill_q) > FILL_MAX) ? FILL_MAX : FILL_W'(start_fill_q);
				id_n = start_id_q;
				bip_n = 8'd0;
				held_n = 8'd0;
			end
			default: begin
				new_res[0].kind = KIND_ERROR;
				new_res[0].block_number = wb_q;
				new_n = 2'd1;
			end
		endcase
		if (new_n != 2'd0) begin
			new_res[new_n - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= 32'd1;
			start_block_q <= '0;
			start_fill_q <= '0;
			start_id_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_BLOCK_COUNT: block_count_q <= cfg.data.value[31:0];
				REG_START_BLOCK: start_block_q <= cfg.data.value[31:0];
				REG_START_FILL:  start_fill_q <= cfg.data.value[8:0];
				REG_START_ID:    start_id_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= '0;
			fill_q <= '0;
			id_q <= '0;
			bip_q <= '0;
			held_q <= '0;
		end else if (load) begin
			wb_q <= wb_n;
			fill_q <= fill_n;
			id_q <= id_n;
			bip_q <= bip_n;
			held_q <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			mode_s1 <= pkt.data.mode;
			payload_s1 <= pkt.data.payload;
			len_s1 <= pkt.data.packet_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= new_n;
		end else if (res.valid && res.ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= new_res[i];
			end
		end else if (res.valid && res.ready) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

`ifndef SYNTHESIS
	// the final result of an item is always the last one buffered
	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.last |-> cnt_q == 2'd1)
		else $error("last result not at buffer tail");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill level beyond data area");

	a_packet_progress: assert property (@(posedge clk) disable iff (!arst_n)
		bip_q != 8'd0 |-> bip_q < held_q)
		else $error("packet byte count reached held length");

	// a restart leaves no result behind
	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		load && mode_s1 == MODE_RESTART |=> cnt_q == 2'd0)
		else $error("restart produced a result");
`endif

endmodule
`default_nettype wire

// File: sim/packer_check_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packer_check_pkg
// Follows write block, fill level and packet id the way the packer should,
// works out the writes, flush events and errors of every accepted item and checks
// the block's results against them in order.
// ----------------------------------------------------------------------------
package packer_check_pkg;
	import lpbp_pkg::*;

	class packer_tracker;
		// register copies
		logic [31:0] block_count;
		logic [31:0] start_block;
		logic [8:0]  start_fill;
		logic [63:0] start_id;
		// packing state
		logic [31:0] write_block;
		logic [9:0]  fill_level;
		logic [63:0] next_id;
		logic [7:0]  bytes_in_packet;
		logic [7:0]  held_length;

		out_item_t   awaited_writes[$];
		int          mismatches;
		int          items_taken;
		int          results_checked;
		int          kind_seen[5];

		function new();
			block_count     = 32'd1;
			start_block     = '0;
			start_fill      = '0;
			start_id        = '0;
			write_block     = '0;
			fill_level      = '0;
			next_id         = '0;
			bytes_in_packet = '0;
			held_length     = '0;
			mismatches      = 0;
			items_taken     = 0;
			results_checked = 0;
			foreach (kind_seen[k]) kind_seen[k] = 0;
		endfunction

		function void push_write(logic [2:0] kind, logic [31:0] blk, logic [9:0] off,
		                         logic [7:0] val, logic [63:0] tid);
			out_item_t w;
			w.kind         = kind;
			w.block_number = blk;
			w.offset       = off[8:0];
			w.byte_value   = val;
			w.trailer_id   = tid;
			w.last         = 1'b0;
			awaited_writes.push_back(w);
		endfunction

		function void take_register(logic [7:0] index, logic [63:0] value);
			case (index)
			REG_BLOCK_COUNT: block_count = value[31:0];
			REG_START_BLOCK: start_block = value[31:0];
			REG_START_FILL:  start_fill  = value[8:0];
			REG_START_ID:    start_id    = value;
			default: ;
			endcase
		endfunction

		function void take_item(in_item_t it);
			int          before_n;
			int          room;
			logic [32:0] bumped;
			before_n = awaited_writes.size();
			items_taken++;
			case (it.mode)
			MODE_DATA: begin
				if (bytes_in_packet == 8'd0 &&
				    (it.packet_length == 8'd0 || int'(it.packet_length) > MAX_PACKET_DEF)) begin
					push_write(KIND_ERROR, write_block, '0, '0, '0);
				end else begin
					if (bytes_in_packet == 8'd0) begin
						held_length = it.packet_length;
						room = (int'(fill_level) < DATA_BYTES_DEF) ?
						       DATA_BYTES_DEF - int'(fill_level) : 0;
						// packet plus its size byte must fit in the room left
						if (room <= int'(held_length)) begin
							push_write(KIND_FULL, write_block, '0, '0, next_id);
							bumped = {1'b0, write_block} + 33'd1;
							write_block = (bumped >= {1'b0, block_count}) ? 32'd0 : bumped[31:0];
							fill_level = '0;
						end
					end
					push_write(KIND_DATA, write_block, fill_level, it.payload, '0);
					fill_level      = fill_level + 10'd1;
					bytes_in_packet = bytes_in_packet + 8'd1;
					if (bytes_in_packet >= held_length) begin
						push_write(KIND_SIZE, write_block, fill_level, held_length, '0);
						fill_level      = fill_level + 10'd1;
						next_id         = next_id + 64'd1;
						bytes_in_packet = '0;
					end
				end
			end
			MODE_FLUSH: push_write(KIND_FLUSH, write_block, '0, '0, next_id);
			MODE_RESTART: begin
				write_block = (start_block < block_count) ? start_block : 32'd0;
				fill_level = (int'(start_fill) > DATA_BYTES_DEF) ?
				             10'(DATA_BYTES_DEF) : {1'b0, start_fill};
				next_id         = start_id;
				bytes_in_packet = '0;
				held_length     = '0;
			end
			default: push_write(KIND_ERROR, write_block, '0, '0, '0);
			endcase
			if (awaited_writes.size() > before_n)
				awaited_writes[awaited_writes.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t result %0d: %s is %0h, should be %0h", $time, results_checked,
				         field, got, want);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			results_checked++;
			if (got.kind <= KIND_ERROR)
				kind_seen[got.kind]++;
			if (awaited_writes.size() == 0) begin
				report_mismatch("kind of unexpected result", 64'(got.kind), '0);
				return;
			end
			want = awaited_writes.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 64'(got.kind), 64'(want.kind));
			if (got.block_number !== want.block_number)
				report_mismatch("block_number", 64'(got.block_number), 64'(want.block_number));
			if (got.offset !== want.offset)
				report_mismatch("offset", 64'(got.offset), 64'(want.offset));
			if (got.byte_value !== want.byte_value)
				report_mismatch("byte_value", 64'(got.byte_value), 64'(want.byte_value));
			if (got.trailer_id !== want.trailer_id)
				report_mismatch("trailer_id", got.trailer_id, want.trailer_id);
			if (got.last !== want.last)
				report_mismatch("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

endpackage
`default_nettype wire

// File: sim/log_packet_block_packer_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_packet_block_packer_tb
// Drives log bytes, bad lengths, unknown modes, flushes and restarts into the
// packer under several register settings, with random gaps and output stalls,
// and checks every result in order against a tracked copy of the block state.
// ----------------------------------------------------------------------------
module log_packet_block_packer_tb;
	import lpbp_pkg::*;
	import packer_check_pkg::*;

	localparam logic [1:0] MODE_UNKNOWN  = 2'd3;
	localparam logic [7:0] REG_UNUSED    = 8'd4;
	localparam int         RANDOM_PHASES = 6;
	localparam int         PHASE_ITEMS   = 85;
	localparam int         SETTLE_CYCLES = 6;
	localparam int         STALL_LIMIT   = 2000;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          steady;
	int            settings_used;
	int            idle_cycles;
	packer_tracker pack_check;

	lpbp_if #(.T(in_item_t))  pkt_ch ();
	lpbp_if #(.T(out_item_t)) res_ch ();
	lpbp_if #(.T(cfg_item_t)) cfg_ch ();

	log_packet_block_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// result side stalls
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= steady || ($urandom_range(99) >= 6);
		end
	end

	// results are checked before the item of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				pack_check.check_result(res_ch.data);
			if (pkt_ch.valid && pkt_ch.ready)
				pack_check.take_item(pkt_ch.data);
			if (cfg_ch.valid && cfg_ch.ready)
				pack_check.take_register(cfg_ch.data.index, cfg_ch.data.value);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[log_packet_block_packer] ERROR");
		$finish;
	end

	task automatic send(input logic [1:0] mode, input logic [7:0] payload,
	                    input logic [7:0] len);
		if (!steady && $urandom_range(99) < 6) begin
			pkt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.data  <= '{mode: mode, payload: payload, packet_length: len};
		do @(posedge clk); while (!pkt_ch.ready);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, value: val};
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic program_regs(input logic [63:0] count, input logic [63:0] first_block,
	                            input logic [63:0] fill, input logic [63:0] first_id);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_BLOCK_COUNT, count);
		write_reg(REG_START_BLOCK, first_block);
		write_reg(REG_START_FILL, fill);
		write_reg(REG_START_ID, first_id);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// restart items give no result, so let the pipeline empty after the last one
	task automatic wait_idle();
		pkt_ch.valid <= 1'b0;
		do @(posedge clk); while (pack_check.awaited_writes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          n;
		int          len;
		int          pick;
		logic [31:0] count;
		logic [31:0] first_block;
		logic [63:0] fill;
		logic [63:0] first_id;
		pkt_ch.valid  = 1'b0;
		pkt_ch.data   = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		arst_n        = 1'b0;
		steady        = 1'b0;
		settings_used = 0;
		pack_check    = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// bad lengths, unknown mode and flushes at the reset setting
		send(MODE_DATA, 8'h00, 8'd0);
		send(MODE_DATA, 8'h11, 8'd251);
		send(MODE_DATA, 8'hFF, 8'hFF);
		send(MODE_UNKNOWN, 8'hFF, 8'hFF);
		send(MODE_FLUSH, 8'h00, 8'h00);
		send(MODE_DATA, 8'hFF, 8'd1);
		// flush and restart inside a packet
		send(MODE_DATA, 8'h00, 8'd3);
		send(MODE_FLUSH, 8'hA5, 8'h5A);
		send(MODE_DATA, 8'hAA, 8'd0);
		send(MODE_RESTART, 8'hFF, 8'hFF);
		send(MODE_DATA, 8'h5A, 8'd250);
		send(MODE_RESTART, 8'h00, 8'h00);
		wait_idle();

		// oversized start fill forces a full block, block and id both wrap
		program_regs(64'd3, 64'd2, 64'd511, '1);
		send(MODE_RESTART, 8'h00, 8'h00);
		send(MODE_DATA, 8'h3C, 8'd1);
		send(MODE_FLUSH, 8'h00, 8'h00);
		wait_idle();

		// zero block count, start block out of range
		program_regs(64'd0, 64'd5, 64'd504, 64'h8000_0000_0000_0000);
		send(MODE_RESTART, 8'h00, 8'h00);
		send(MODE_DATA, 8'hC3, 8'd250);
		send(MODE_RESTART, 8'h00, 8'h00);
		wait_idle();

		// largest block count, starting on its last block
		program_regs(64'hFFFF_FFFF, 64'hFFFF_FFFE, 64'd503, 64'hFFFF_FFFF_FFFF_FFFE);
		send(MODE_RESTART, 8'h00, 8'h00);
		send(MODE_DATA, 8'h01, 8'd1);
		send(MODE_DATA, 8'h02, 8'd2);
		send(MODE_DATA, 8'h03, 8'h77);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(3))
			0: count = 32'd1;
			1: count = $urandom_range(2, 5);
			2: count = 32'hFFFF_FFFF;
			default: count = $urandom;
			endcase
			case ($urandom_range(3))
			0: first_block = count - 32'd1;
			1: first_block = $urandom_range(0, 5);
			2: first_block = 32'hFFFF_FFFF;
			default: first_block = $urandom;
			endcase
			fill = {$urandom, $urandom};
			case ($urandom_range(3))
			0: fill[8:0] = 9'd0;
			1: fill[8:0] = 9'($urandom_range(440, 511));
			2: fill[8:0] = 9'd504;
			default: ;
			endcase
			case ($urandom_range(2))
			0: first_id = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
			1: first_id = '0;
			default: first_id = {$urandom, $urandom};
			endcase
			steady <= (p == 2);
			program_regs({$urandom, count}, {$urandom, first_block}, fill, first_id);
			send(MODE_RESTART, 8'($urandom), 8'($urandom));

			n = 0;
			while (n < PHASE_ITEMS) begin
				pick = int'($urandom_range(99));
				if (pick < 75) begin
					len = int'($urandom_range(1, 24));
					if ($urandom_range(11) == 0)
						len = int'($urandom_range(100, 250));
					if ($urandom_range(24) == 0)
						len = 250;
					for (int i = 0; i < len; i++) begin
						// the phase ends on its item budget, even inside a packet
						if (n >= PHASE_ITEMS)
							break;
						if (i > 0 && $urandom_range(199) == 0) begin
							send(MODE_RESTART, 8'($urandom), 8'($urandom));
							n++;
							break;
						end
						if (i > 0 && $urandom_range(99) < 3) begin
							send(MODE_FLUSH, 8'($urandom), 8'($urandom));
							n++;
						end
						// length only counts on the first byte
						send(MODE_DATA, 8'($urandom), (i == 0) ? 8'(len) : 8'($urandom));
						n++;
					end
				end else begin
					if (pick < 83)
						send(MODE_RESTART, 8'($urandom), 8'($urandom));
					else if (pick < 90)
						send(MODE_FLUSH, 8'($urandom), 8'($urandom));
					else if (pick < 95)
						send(MODE_DATA, 8'($urandom),
						     ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(251, 255)));
					else
						send(MODE_UNKNOWN, 8'($urandom), 8'($urandom));
					n++;
				end
			end
			wait_idle();
		end

		$display("covered %0d items under %0d register settings, %0d results checked",
		         pack_check.items_taken, settings_used, pack_check.results_checked);
		$display("results: %0d data, %0d size, %0d full-block flush, %0d flush, %0d error",
		         pack_check.kind_seen[KIND_DATA], pack_check.kind_seen[KIND_SIZE],
		         pack_check.kind_seen[KIND_FULL], pack_check.kind_seen[KIND_FLUSH],
		         pack_check.kind_seen[KIND_ERROR]);
		if (pack_check.mismatches == 0)
			$display("[log_packet_block_packer] OK");
		else
			$display("[log_packet_block_packer] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
